// ===== src/sipq_pkg.sv =====
// Shared types and constants for the sorted-insert priority queue.
package sipq_pkg;

   localparam int DefaultDepth        = 16;
   localparam int DefaultKeyWidth     = 16;
   localparam int DefaultPayloadWidth = 24;

   // Mode field of an input transaction.
   localparam logic ModeEnqueue = 1'b0;
   localparam logic ModeDequeue = 1'b1;

   // Operation broadcast to every cell of the row.
   typedef enum logic [1:0] {
      OpHold   = 2'd0,
      OpInsert = 2'd1,
      OpRemove = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      StOk    = 2'd0,
      StFull  = 2'd1,
      StEmpty = 2'd2
   } status_type;

endpackage

// ===== src/sorted_insert_priority_queue_unit.sv =====
// Top level of the sorted-insert priority queue: cell row, occupancy count and result register.
// The queue accepts one transaction in every clock cycle and busy is never raised. Every cell
// compares its key with the incoming one in parallel, and the cells from the insertion point
// on (on a dequeue, the whole row) shift by one place; the registered result strobe rsp_valid
// rises in the cycle after acceptance and lasts one cycle. The receiver cannot stall the
// results. Entries with equal keys leave in arrival order; a refused enqueue or dequeue leaves
// the contents untouched and is reported in rsp_status with zero key and payload.
module sorted_insert_priority_queue_unit
   import sipq_pkg::*;
#(
   parameter int Depth        = DefaultDepth,
   parameter int KeyWidth     = DefaultKeyWidth,
   parameter int PayloadWidth = DefaultPayloadWidth,
   localparam int CountWidth  = $clog2(Depth + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_mode,
   input  logic [KeyWidth-1:0]     req_entry_key,
   input  logic [PayloadWidth-1:0] req_entry_payload,
   output logic                    rsp_valid,
   output logic [KeyWidth-1:0]     rsp_out_key,
   output logic [PayloadWidth-1:0] rsp_out_payload,
   output logic [CountWidth-1:0]   rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full,
   output status_type              rsp_status
);

   logic [KeyWidth-1:0]     cell_key     [Depth];
   logic [PayloadWidth-1:0] cell_payload [Depth];
   logic [Depth-1:0]        cell_valid;
   logic [Depth-1:0]        cell_past;

   logic                    accept;
   logic                    is_full_now;
   logic                    is_empty_now;
   cell_ctrl_type           ctrl;
   status_type              status_now;
   logic [CountWidth-1:0]   count_ff, count_in;

   logic                    rsp_valid_ff;
   logic [KeyWidth-1:0]     rsp_key_ff, rsp_key_in;
   logic [PayloadWidth-1:0] rsp_payload_ff, rsp_payload_in;
   logic [CountWidth-1:0]   rsp_count_ff;
   logic                    rsp_empty_ff, rsp_full_ff;
   status_type              rsp_status_ff;

   assign busy         = 1'b0;
   assign accept       = start && !busy;
   assign is_full_now  = (count_ff == CountWidth'(Depth));
   assign is_empty_now = (count_ff == '0);

   always_comb begin
      ctrl.op        = OpHold;
      status_now     = StOk;
      count_in       = count_ff;
      rsp_key_in     = '0;
      rsp_payload_in = '0;
      if (accept) begin
         if (req_mode == ModeEnqueue) begin
            if (is_full_now) begin
               status_now = StFull;
            end else begin
               ctrl.op  = OpInsert;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty_now) begin
               status_now = StEmpty;
            end else begin
               ctrl.op        = OpRemove;
               count_in       = count_ff - 1'b1;
               rsp_key_in     = cell_key[0];
               rsp_payload_in = cell_payload[0];
            end
         end
      end
   end

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic [KeyWidth-1:0]     left_key, right_key;
      logic [PayloadWidth-1:0] left_payload, right_payload;
      logic                    left_valid, left_past, right_valid;

      // The head cell sees a valid neighbour that is never past the insertion point.
      if (i == 0) begin : g_head
         assign left_key     = '0;
         assign left_payload = '0;
         assign left_valid   = 1'b1;
         assign left_past    = 1'b0;
      end else begin : g_body
         assign left_key     = cell_key[i-1];
         assign left_payload = cell_payload[i-1];
         assign left_valid   = cell_valid[i-1];
         assign left_past    = cell_past[i-1];
      end

      if (i == Depth - 1) begin : g_tail
         assign right_key     = '0;
         assign right_payload = '0;
         assign right_valid   = 1'b0;
      end else begin : g_inner
         assign right_key     = cell_key[i+1];
         assign right_payload = cell_payload[i+1];
         assign right_valid   = cell_valid[i+1];
      end

      sipq_cell #(
         .KeyWidth     (KeyWidth),
         .PayloadWidth (PayloadWidth)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .new_key       (req_entry_key),
         .new_payload   (req_entry_payload),
         .left_key      (left_key),
         .left_payload  (left_payload),
         .left_valid    (left_valid),
         .left_past     (left_past),
         .right_key     (right_key),
         .right_payload (right_payload),
         .right_valid   (right_valid),
         .cell_key      (cell_key[i]),
         .cell_payload  (cell_payload[i]),
         .cell_valid    (cell_valid[i]),
         .cell_past     (cell_past[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_count_ff   <= count_in;
      rsp_empty_ff   <= (count_in == '0);
      rsp_full_ff    <= (count_in == CountWidth'(Depth));
      rsp_status_ff  <= status_now;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_status      = rsp_status_ff;

   // Every accepted transaction produces exactly one strobe on the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction did not produce a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result strobe without an accepted transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("occupancy count exceeds depth");

   // The head and tail cells must agree with the occupied prefix given by the count.
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell occupancy disagrees with count");

   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[Depth-1] == (count_ff == CountWidth'(Depth)))
      else $error("tail cell occupancy disagrees with count");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != StOk) |-> (rsp_out_key == '0) && (rsp_out_payload == '0))
      else $error("refused transaction returned a non-zero entry");

endmodule

// ===== src/sipq_cell.sv =====
// One storage cell of the sorted row: holds an entry and shifts with its neighbours.
module sipq_cell
   import sipq_pkg::*;
#(
   parameter int KeyWidth     = DefaultKeyWidth,
   parameter int PayloadWidth = DefaultPayloadWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic [KeyWidth-1:0]     new_key,
   input  logic [PayloadWidth-1:0] new_payload,
   input  logic [KeyWidth-1:0]     left_key,
   input  logic [PayloadWidth-1:0] left_payload,
   input  logic                    left_valid,
   input  logic                    left_past,
   input  logic [KeyWidth-1:0]     right_key,
   input  logic [PayloadWidth-1:0] right_payload,
   input  logic                    right_valid,
   output logic [KeyWidth-1:0]     cell_key,
   output logic [PayloadWidth-1:0] cell_payload,
   output logic                    cell_valid,
   output logic                    cell_past
);

   logic [KeyWidth-1:0]     key_ff, key_in;
   logic [PayloadWidth-1:0] payload_ff, payload_in;
   logic                    valid_ff, valid_in;

   // A cell lies at or beyond the insertion point when it is empty or its key
   // is strictly greater, so equal keys stay ahead of the newcomer.
   assign cell_past = !valid_ff || (key_ff > new_key);

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      valid_in   = valid_ff;
      case (ctrl.op)
         OpInsert: begin
            if (cell_past) begin
               if (left_past) begin
                  key_in     = left_key;
                  payload_in = left_payload;
               end else begin
                  key_in     = new_key;
                  payload_in = new_payload;
               end
               valid_in = valid_ff || left_valid;
            end
         end
         OpRemove: begin
            key_in     = right_key;
            payload_in = right_payload;
            valid_in   = right_valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign cell_key     = key_ff;
   assign cell_payload = payload_ff;
   assign cell_valid   = valid_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted-insert priority queue unit.
module tb_top;
   import sipq_pkg::*;

   localparam int Depth        = DefaultDepth;
   localparam int KeyWidth     = DefaultKeyWidth;
   localparam int PayloadWidth = DefaultPayloadWidth;
   localparam int CountWidth   = $clog2(Depth + 1);
   localparam int RandomItems  = 700;

   typedef struct packed {
      logic [KeyWidth-1:0]     key;
      logic [PayloadWidth-1:0] payload;
      logic [CountWidth-1:0]   count;
      logic                    empty;
      logic                    full;
      status_type              status;
   } queue_result_type;

   class queue_shadow_type;
      logic [KeyWidth-1:0]     stored_keys[Depth];
      logic [PayloadWidth-1:0] stored_payloads[Depth];
      int                      stored_total;
      queue_result_type        awaited[$];
      int                      mismatches;
      int                      enqueues;
      int                      dequeues;
      int                      refused_full;
      int                      refused_empty;
      int                      times_full;

      function new();
         stored_total  = 0;
         mismatches    = 0;
         enqueues      = 0;
         dequeues      = 0;
         refused_full  = 0;
         refused_empty = 0;
         times_full    = 0;
      endfunction

      // Applies one transaction to the shadow contents and returns the result it should give.
      function queue_result_type apply_transaction(logic mode, logic [KeyWidth-1:0] key,
                                                   logic [PayloadWidth-1:0] payload);
         queue_result_type res;
         int               pos;
         int               i;
         res.key     = '0;
         res.payload = '0;
         res.status  = StOk;
         if (mode == ModeEnqueue) begin
            enqueues++;
            if (stored_total >= Depth) begin
               res.status = StFull;
               refused_full++;
            end else begin
               // Entries with a strictly greater key move up, so equal keys keep arrival order.
               pos = stored_total;
               while (pos > 0 && stored_keys[pos-1] > key) begin
                  stored_keys[pos]     = stored_keys[pos-1];
                  stored_payloads[pos] = stored_payloads[pos-1];
                  pos--;
               end
               stored_keys[pos]     = key;
               stored_payloads[pos] = payload;
               stored_total++;
               if (stored_total == Depth) times_full++;
            end
         end else begin
            dequeues++;
            if (stored_total == 0) begin
               res.status = StEmpty;
               refused_empty++;
            end else begin
               res.key     = stored_keys[0];
               res.payload = stored_payloads[0];
               for (i = 1; i < stored_total; i++) begin
                  stored_keys[i-1]     = stored_keys[i];
                  stored_payloads[i-1] = stored_payloads[i];
               end
               stored_total--;
            end
         end
         res.count = CountWidth'(stored_total);
         res.empty = (stored_total == 0);
         res.full  = (stored_total == Depth);
         return res;
      endfunction

      function void note_request(logic mode, logic [KeyWidth-1:0] key,
                                 logic [PayloadWidth-1:0] payload);
         awaited.push_back(apply_transaction(mode, key, payload));
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("%0t ns mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_result(queue_result_type got);
         queue_result_type want;
         if (awaited.size() == 0) begin
            report("result with no transaction outstanding", got.status, 0);
            return;
         end
         want = awaited.pop_front();
         if (got.key !== want.key)         report("out_key", got.key, want.key);
         if (got.payload !== want.payload) report("out_payload", got.payload, want.payload);
         if (got.count !== want.count)     report("entry_count", got.count, want.count);
         if (got.empty !== want.empty)     report("is_empty", got.empty, want.empty);
         if (got.full !== want.full)       report("is_full", got.full, want.full);
         if (got.status !== want.status)   report("status", got.status, want.status);
      endtask

      task close_out();
         if (awaited.size() != 0) report("results never delivered", awaited.size(), 0);
      endtask
   endclass

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic                    req_mode          = ModeEnqueue;
   logic [KeyWidth-1:0]     req_entry_key     = '0;
   logic [PayloadWidth-1:0] req_entry_payload = '0;
   logic                    rsp_valid;
   logic [KeyWidth-1:0]     rsp_out_key;
   logic [PayloadWidth-1:0] rsp_out_payload;
   logic [CountWidth-1:0]   rsp_entry_count;
   logic                    rsp_is_empty;
   logic                    rsp_is_full;
   status_type              rsp_status;

   queue_shadow_type shadow = new();
   queue_result_type observed;

   sorted_insert_priority_queue_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_entry_key     (req_entry_key),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   // Results cannot be held off, so every strobed cycle is taken at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         observed = '{rsp_out_key, rsp_out_payload, rsp_entry_count,
                      rsp_is_empty, rsp_is_full, rsp_status};
         shadow.check_result(observed);
      end
   end

   task automatic send_transaction(input logic mode, input logic [KeyWidth-1:0] key,
                                   input logic [PayloadWidth-1:0] payload);
      start             <= 1'b1;
      req_mode          <= mode;
      req_entry_key     <= key;
      req_entry_payload <= payload;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_request(mode, key, payload);
   endtask

   task automatic idle_gap(input bit allowed, output bit idled);
      int pick;
      int cycles;
      pick   = $urandom_range(0, 99);
      cycles = 0;
      if (allowed) begin
         if (pick >= 90)      cycles = $urandom_range(8, 30);
         else if (pick >= 60) cycles = $urandom_range(1, 3);
      end
      idled = (cycles > 0);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Keys lean towards a narrow range so that equal keys meet often in the store.
   function automatic logic [KeyWidth-1:0] pick_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return KeyWidth'($urandom_range(0, 15));
      if (pick == 5) return ($urandom_range(0, 1) != 0) ? {KeyWidth{1'b1}} : {KeyWidth{1'b0}};
      return KeyWidth'($urandom);
   endfunction

   function automatic logic [PayloadWidth-1:0] pick_payload();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return {PayloadWidth{1'b0}};
      if (pick == 1) return {PayloadWidth{1'b1}};
      return PayloadWidth'($urandom);
   endfunction

   initial begin
      int issued;
      int phase_len;
      int enqueue_odds;
      int i;
      bit gappy;
      bit idled;
      idled = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_transaction(ModeDequeue, '0, '0);
      send_transaction(ModeEnqueue, {KeyWidth{1'b1}}, {PayloadWidth{1'b1}});
      send_transaction(ModeEnqueue, '0, '0);
      send_transaction(ModeEnqueue, KeyWidth'(16'h8000), PayloadWidth'(24'h000001));
      send_transaction(ModeEnqueue, KeyWidth'(16'h8000), PayloadWidth'(24'h000002));
      send_transaction(ModeEnqueue, KeyWidth'(16'h7fff), PayloadWidth'(24'haaaaaa));
      send_transaction(ModeEnqueue, KeyWidth'(16'h8000), PayloadWidth'(24'h000003));
      send_transaction(ModeEnqueue, '0, PayloadWidth'(24'h555555));
      // One dequeue more than was stored, so the last one finds the queue empty.
      repeat (8) send_transaction(ModeDequeue, '0, '0);
      idled = 1'b0;

      // Phases lean towards filling, draining or a balanced mix.
      issued = 0;
      while (issued < RandomItems) begin
         case ($urandom_range(0, 2))
            0: begin
               enqueue_odds = 85;
            end
            1: begin
               enqueue_odds = 15;
            end
            default: begin
               enqueue_odds = 50;
            end
         endcase
         phase_len = $urandom_range(10, 50);
         gappy     = ($urandom_range(0, 3) != 0);
         for (i = 0; i < phase_len; i++) begin
            send_transaction(($urandom_range(0, 99) < enqueue_odds) ? ModeEnqueue : ModeDequeue,
                             pick_key(), pick_payload());
            idle_gap(gappy, idled);
            issued++;
         end
      end

      // A gap that has just ended already left start low.
      if (!idled) start <= 1'b0;
      i = 0;
      while (shadow.awaited.size() != 0 && i < 100) begin
         @(posedge clock);
         i++;
      end
      repeat (4) @(posedge clock);
      shadow.close_out();

      $display("%0d enqueues (%0d refused as full), %0d dequeues (%0d refused as empty)",
               shadow.enqueues, shadow.refused_full, shadow.dequeues, shadow.refused_empty);
      $display("queue filled to capacity %0d times, %0d mismatches counted",
               shadow.times_full, shadow.mismatches);
      if (shadow.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: stimulus or results stalled");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sipq_pkg.sv
src/sipq_cell.sv
src/sorted_insert_priority_queue_unit.sv
tb/tb_top.sv
